>>> sv/acsc_pkg.sv
// ----------------------------------------------------------------------------
// acsc_pkg
// Types and constants shared by the alarm clock snooze controller.
// ----------------------------------------------------------------------------
package acsc_pkg;

  localparam int TIMER_WIDTH_DEFAULT = 10;
  localparam int CFG_WIDTH = 10;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int HOUR_WIDTH = 5;
  localparam int MINUTE_WIDTH = 6;

  localparam logic [CFG_WIDTH-1:0] RING_SECONDS_RESET = CFG_WIDTH'(60 * 10);
  localparam logic [CFG_WIDTH-1:0] SNOOZE_SECONDS_RESET = CFG_WIDTH'(60 * 5);
  localparam logic [HOUR_WIDTH-1:0] HOUR_LAST = HOUR_WIDTH'(24 - 1);
  localparam logic [MINUTE_WIDTH-1:0] MINUTE_LAST = MINUTE_WIDTH'(60 - 1);

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RING_SECONDS = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SNOOZE_SECONDS = CFG_INDEX_WIDTH'(1);

  typedef struct packed {
    logic [HOUR_WIDTH-1:0]   now_hour;
    logic [MINUTE_WIDTH-1:0] now_minute;
    logic                    second_tick;
    logic                    enable;
    logic                    snooze_press;
    logic                    mute_press;
    logic                    set_press;
    logic                    set_minute;
    logic                    on_set_screen;
  } item_t;

  typedef struct packed {
    logic                    buzzer_on;
    logic                    ringing;
    logic                    snoozing;
    logic                    mute_flag;
    logic [HOUR_WIDTH-1:0]   set_hour;
    logic [MINUTE_WIDTH-1:0] set_min;
  } result_t;

  typedef struct packed {
    logic                    active;
    logic                    snoozed;
    logic                    muted;
    logic [HOUR_WIDTH-1:0]   alarm_hour;
    logic [MINUTE_WIDTH-1:0] alarm_minute;
  } flags_t;

endpackage

>>> sv/acsc_step.sv
// ----------------------------------------------------------------------------
// acsc_step
// Next-state and result logic for one request of the alarm controller.
// ----------------------------------------------------------------------------
module acsc_step #(
  parameter int TIMER_WIDTH = acsc_pkg::TIMER_WIDTH_DEFAULT
) (
  input  acsc_pkg::item_t                 item,
  input  acsc_pkg::flags_t                flags,
  input  logic [TIMER_WIDTH-1:0]          ring_count,
  input  logic [TIMER_WIDTH-1:0]          snooze_count,
  input  logic [acsc_pkg::CFG_WIDTH-1:0]  ring_seconds,
  input  logic [acsc_pkg::CFG_WIDTH-1:0]  snooze_seconds,
  output acsc_pkg::flags_t                flags_next,
  output logic [TIMER_WIDTH-1:0]          ring_count_next,
  output logic [TIMER_WIDTH-1:0]          snooze_count_next,
  output acsc_pkg::result_t               result_next
);

  localparam int CW = TIMER_WIDTH + acsc_pkg::CFG_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};

  always_comb begin
    logic                                active;
    logic                                snoozed;
    logic                                muted;
    logic [acsc_pkg::HOUR_WIDTH-1:0]     hr;
    logic [acsc_pkg::MINUTE_WIDTH-1:0]   mn;
    logic [TIMER_WIDTH-1:0]              rc;
    logic [TIMER_WIDTH-1:0]              sc;
    logic                                match;

    active  = flags.active;
    snoozed = flags.snoozed;
    muted   = flags.muted;
    hr      = flags.alarm_hour;
    mn      = flags.alarm_minute;
    rc      = ring_count;
    sc      = snooze_count;

    if (item.snooze_press && active) begin
      snoozed = 1'b1;
      active  = 1'b0;
    end
    if (item.mute_press) begin
      muted = 1'b1;
    end

    if (!active && !item.enable && !snoozed && !muted) begin
      rc = '0;
      sc = '0;
      if (item.on_set_screen && item.set_press) begin
        if (item.set_minute) begin
          mn = (mn == acsc_pkg::MINUTE_LAST) ? '0 : mn + 1'b1;
        end else begin
          hr = (hr == acsc_pkg::HOUR_LAST) ? '0 : hr + 1'b1;
        end
      end
    end

    match = (item.now_hour == hr) && (item.now_minute == mn);

    if (!active && item.enable && !snoozed) begin
      rc = '0;
      sc = '0;
      if (!muted) begin
        if (match) begin
          active = 1'b1;
        end
      end else if (!match) begin
        muted = 1'b0;
      end
    end

    if (active && item.enable && !snoozed && !muted && item.second_tick) begin
      if (rc != CNT_MAX) begin
        rc = rc + 1'b1;
      end
      if ((CW'(rc) >= CW'(ring_seconds)) || (rc == CNT_MAX)) begin
        rc     = '0;
        active = 1'b0;
      end
    end

    if (!active && item.enable && snoozed && !muted) begin
      rc = '0;
      if (item.second_tick) begin
        if (sc != CNT_MAX) begin
          sc = sc + 1'b1;
        end
        if ((CW'(sc) >= CW'(snooze_seconds)) || (sc == CNT_MAX)) begin
          sc      = '0;
          active  = 1'b1;
          snoozed = 1'b0;
        end
      end
    end

    if ((active || snoozed) && item.enable && muted) begin
      active  = 1'b0;
      snoozed = 1'b0;
    end

    flags_next.active       = active;
    flags_next.snoozed      = snoozed;
    flags_next.muted        = muted;
    flags_next.alarm_hour   = hr;
    flags_next.alarm_minute = mn;
    ring_count_next         = rc;
    snooze_count_next       = sc;

    result_next.buzzer_on = active && item.enable && !snoozed && !muted;
    result_next.ringing   = active;
    result_next.snoozing  = snoozed;
    result_next.mute_flag = muted;
    result_next.set_hour  = hr;
    result_next.set_min   = mn;
  end

endmodule

>>> sv/alarm_clock_snooze_controller.sv
// ----------------------------------------------------------------------------
// alarm_clock_snooze_controller
// Alarm controller with settable alarm time, timed ringing, snooze and mute.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the result is not
// stalled and presents one result per request: a request is captured in an
// input register, and the next-state logic then updates the alarm state and
// loads the result register. A stalled result holds both registers and
// stalls the input once the input register is full. Ring and snooze
// periods are counted in second ticks and are set by the ring_seconds and
// snooze_seconds registers, which should be written only while no request is
// in flight.
module alarm_clock_snooze_controller #(
  parameter int TIMER_WIDTH = acsc_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  acsc_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output acsc_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [acsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [acsc_pkg::CFG_WIDTH-1:0]      cfg_data
);

  logic                           in_valid;
  acsc_pkg::item_t                in_item;
  acsc_pkg::flags_t               flags;
  acsc_pkg::flags_t               flags_next;
  logic [TIMER_WIDTH-1:0]         ring_count;
  logic [TIMER_WIDTH-1:0]         ring_count_next;
  logic [TIMER_WIDTH-1:0]         snooze_count;
  logic [TIMER_WIDTH-1:0]         snooze_count_next;
  logic [acsc_pkg::CFG_WIDTH-1:0] ring_seconds;
  logic [acsc_pkg::CFG_WIDTH-1:0] snooze_seconds;
  acsc_pkg::result_t              result_next;
  logic                           advance;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = in_valid && !advance;
  assign cfg_ready  = 1'b1;

  acsc_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .item              (in_item),
    .flags             (flags),
    .ring_count        (ring_count),
    .snooze_count      (snooze_count),
    .ring_seconds      (ring_seconds),
    .snooze_seconds    (snooze_seconds),
    .flags_next        (flags_next),
    .ring_count_next   (ring_count_next),
    .snooze_count_next (snooze_count_next),
    .result_next       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_seconds   <= acsc_pkg::RING_SECONDS_RESET;
      snooze_seconds <= acsc_pkg::SNOOZE_SECONDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        acsc_pkg::REG_RING_SECONDS:   ring_seconds   <= cfg_data;
        acsc_pkg::REG_SNOOZE_SECONDS: snooze_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags        <= '0;
      ring_count   <= '0;
      snooze_count <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_valid;
      if (in_valid) begin
        flags        <= flags_next;
        ring_count   <= ring_count_next;
        snooze_count <= snooze_count_next;
      end
    end
    if (advance && in_valid) begin
      result <= result_next;
    end
  end

endmodule
